@@ rtl/core/pal_pkg.sv @@
// shared types and constants for the positional array list
`timescale 1ns / 1ps
`default_nettype none

package pal_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam int CMD_W   = 3;
  localparam int POS_W   = 5;
  localparam int VALUE_W = 32;
  localparam int CNT_W   = 5;

  localparam int IN_W  = 40;
  localparam int OUT_W = 48;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_DELETE = 3'd1,
    CMD_GET    = 3'd2,
    CMD_LOCATE = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    SH_NONE   = 2'd0,
    SH_INSERT = 2'd1,
    SH_DELETE = 2'd2
  } shift_t;

  typedef enum logic [1:0] {
    HM_NONE  = 2'd0,
    HM_POS   = 2'd1,
    HM_MATCH = 2'd2
  } hit_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    shift_t shift;
    hit_t   mode;
    logic   load;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/core/positional_array_list.sv @@
// Positional array list: fixed-capacity ordered list of signed 32-bit values.
//
// Commands arrive on the s_* stream, one transfer per command; each command
// gives exactly one result transfer on the m_* stream.
// Commands: insert at a 1-based position, delete at a position (returns the
// removed value), get by position, locate the first position of a value,
// clear. Bad positions, an insert into a full list and unknown commands give
// status 1. Every result carries the new length and an empty flag.
//
// After its transfer a command passes through execute (all cells shift and
// capture), then a scan in which the hit chain walks down the row of cells,
// then done, in which the result is loaded into the output register. The next
// command is taken once the previous one has left the cell row, so the block
// does not take a new command before the last result has been loaded.
// A result waiting in the output register does not stop the next command from
// being taken; if the receiver stalls, the following result waits in the
// cells until the output register is free.
// Reset empties the list and drops any pending result.
`timescale 1ns / 1ps
`default_nettype none

module positional_array_list #(
  parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      s_tvalid,
  output logic                     s_tready,
  // command[2:0], position[7:3], value[39:8]
  input  wire [pal_pkg::IN_W-1:0]  s_tdata,
  output logic                     m_tvalid,
  input  wire                      m_tready,
  // status[0], data_out[32:1], found_position[37:33], count[42:38],
  // is_empty[43], zero[47:44]
  output logic [pal_pkg::OUT_W-1:0] m_tdata
);
  import pal_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t state;
  logic [IW-1:0] scan_cnt;

  logic [CMD_W-1:0]   cmd_q;
  logic [POS_W-1:0]   pos_q;
  logic [VALUE_W-1:0] val_q;

  logic [CW-1:0] fill_count;
  logic [CW-1:0] fill_count_next;
  logic          res_status;
  logic          res_status_next;
  logic          res_locate;

  cell_ctrl_t    ctrl;
  logic [IW-1:0] tgt;
  logic [PW-1:0] pos_ext;
  logic [PW-1:0] cnt_ext;
  logic          ins_ok;
  logic          rd_ok;

  logic [VALUE_W-1:0] entry_w   [CAPACITY];
  logic [VALUE_W-1:0] left_w    [CAPACITY];
  logic [VALUE_W-1:0] right_w   [CAPACITY];
  logic               chain_hit [CAPACITY+1];
  logic [IW-1:0]      chain_idx [CAPACITY+1];
  logic [VALUE_W-1:0] chain_data[CAPACITY+1];

  logic               out_status;
  logic [VALUE_W-1:0] out_data;
  logic [CNT_W-1:0]   out_found;
  logic [CNT_W-1:0]   out_count;
  logic               out_empty;
  logic               out_load;

  assign s_tready = (state == ST_IDLE);
  assign out_load = (state == ST_DONE) && (!m_tvalid || m_tready);

  // position checks against the length before the command
  assign pos_ext = PW'(pos_q);
  assign cnt_ext = PW'(fill_count);
  assign ins_ok  = (pos_q != '0) && (pos_ext <= cnt_ext + PW'(1))
                && (cnt_ext < PW'(CAPACITY));
  assign rd_ok   = (pos_q != '0) && (pos_ext <= cnt_ext);
  assign tgt     = IW'(pos_ext - PW'(1));

  always_comb begin
    ctrl            = '{shift: SH_NONE, mode: HM_NONE, load: 1'b0};
    fill_count_next = fill_count;
    res_status_next = 1'b0;
    if (state == ST_EXEC) begin
      ctrl.load = 1'b1;
      case (cmd_q)
        CMD_INSERT: begin
          if (ins_ok) begin
            ctrl.shift      = SH_INSERT;
            fill_count_next = fill_count + CW'(1);
          end else begin
            res_status_next = 1'b1;
          end
        end
        CMD_DELETE: begin
          if (rd_ok) begin
            ctrl.shift      = SH_DELETE;
            ctrl.mode       = HM_POS;
            fill_count_next = fill_count - CW'(1);
          end else begin
            res_status_next = 1'b1;
          end
        end
        CMD_GET: begin
          if (rd_ok) begin
            ctrl.mode = HM_POS;
          end else begin
            res_status_next = 1'b1;
          end
        end
        CMD_LOCATE: ctrl.mode = HM_MATCH;
        CMD_CLEAR:  fill_count_next = '0;
        default:    res_status_next = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      scan_cnt   <= '0;
      fill_count <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          fill_count <= fill_count_next;
          scan_cnt   <= '0;
          state      <= (CAPACITY > 1) ? ST_SCAN : ST_DONE;
        end
        ST_SCAN: begin
          if (scan_cnt == IW'(CAPACITY - 2)) begin
            state <= ST_DONE;
          end
          scan_cnt <= scan_cnt + IW'(1);
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd_q <= s_tdata[2:0];
      pos_q <= s_tdata[7:3];
      val_q <= s_tdata[39:8];
    end
    if (state == ST_EXEC) begin
      res_status <= res_status_next;
      res_locate <= (cmd_q == CMD_LOCATE);
    end
  end

  // row of cells
  assign chain_hit[CAPACITY]  = 1'b0;
  assign chain_idx[CAPACITY]  = '0;
  assign chain_data[CAPACITY] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_w[i] = '0;
    end else begin : g_mid
      assign left_w[i] = entry_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w[i] = '0;
    end else begin : g_inner
      assign right_w[i] = entry_w[i+1];
    end

    pal_cell #(
      .CAPACITY (CAPACITY),
      .IDX      (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .tgt      (tgt),
      .count    (fill_count),
      .value    (val_q),
      .left     (left_w[i]),
      .right    (right_w[i]),
      .entry    (entry_w[i]),
      .in_hit   (chain_hit[i+1]),
      .in_idx   (chain_idx[i+1]),
      .in_data  (chain_data[i+1]),
      .out_hit  (chain_hit[i]),
      .out_idx  (chain_idx[i]),
      .out_data (chain_data[i])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= res_status;
      out_data   <= (chain_hit[0] && !res_locate) ? chain_data[0] : '0;
      out_found  <= (chain_hit[0] && res_locate)
                    ? CNT_W'(CW'(chain_idx[0]) + CW'(1)) : '0;
      out_count  <= CNT_W'(fill_count);
      out_empty  <= (fill_count == '0);
    end
  end

  assign m_tdata = {4'b0000, out_empty, out_count, out_found, out_data, out_status};

  // the length never passes the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CW'(CAPACITY))
    else $error("fill count above capacity");

  // the length only moves in the cycle the cells execute
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    (state != ST_EXEC) |=> $stable(fill_count))
    else $error("fill count changed outside execute");

  // an insert into a full list is refused
  a_full_insert: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC && cmd_q == CMD_INSERT && fill_count == CW'(CAPACITY))
    |=> (res_status && $stable(fill_count)))
    else $error("insert into full list not refused");

  // an accepted command goes straight to execute
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ST_EXEC))
    else $error("accepted command did not execute");

  // a result is only loaded when the output register is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !out_load)
    else $error("pending result overwritten");

endmodule

`default_nettype wire

@@ rtl/core/pal_cell.sv @@
// one list cell: holds an entry, shifts with its neighbors, and forwards the hit chain
`timescale 1ns / 1ps
`default_nettype none

module pal_cell #(
  parameter int CAPACITY = pal_pkg::CAPACITY_DEF,
  parameter int IDX = 0,
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  wire                        clk,
  input  wire                        rst,
  input  pal_pkg::cell_ctrl_t        ctrl,
  input  wire [IW-1:0]               tgt,
  input  wire [CW-1:0]               count,
  input  wire [pal_pkg::VALUE_W-1:0] value,
  input  wire [pal_pkg::VALUE_W-1:0] left,
  input  wire [pal_pkg::VALUE_W-1:0] right,
  output logic [pal_pkg::VALUE_W-1:0] entry,
  input  wire                        in_hit,
  input  wire [IW-1:0]               in_idx,
  input  wire [pal_pkg::VALUE_W-1:0] in_data,
  output logic                       out_hit,
  output logic [IW-1:0]              out_idx,
  output logic [pal_pkg::VALUE_W-1:0] out_data
);
  import pal_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);
  localparam logic [CW-1:0] MY_CNT = CW'(IDX);

  logic hit_local;

  always_comb begin
    hit_local = 1'b0;
    case (ctrl.mode)
      HM_POS:   hit_local = (MY_IDX == tgt);
      HM_MATCH: hit_local = (MY_CNT < count) && (entry == value);
      default:  hit_local = 1'b0;
    endcase
  end

  // entry storage, no reset: only slots below the fill count are ever read
  always_ff @(posedge clk) begin
    case (ctrl.shift)
      SH_INSERT: begin
        if (MY_IDX == tgt) begin
          entry <= value;
        end else if (MY_IDX > tgt) begin
          entry <= left;
        end
      end
      SH_DELETE: begin
        if (MY_IDX >= tgt) begin
          entry <= right;
        end
      end
      default: ;
    endcase
  end

  // hit chain: a cell with no hit takes the hit held by its right neighbor, so the lowest hit walks toward cell 0
  always_ff @(posedge clk) begin
    if (rst) begin
      out_hit <= 1'b0;
    end else if (ctrl.load) begin
      out_hit <= hit_local;
    end else if (!out_hit) begin
      out_hit <= in_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      out_idx  <= MY_IDX;
      out_data <= entry;
    end else if (!out_hit) begin
      out_idx  <= in_idx;
      out_data <= in_data;
    end
  end

endmodule

`default_nettype wire
